@@ sv/slx_pkg.sv @@
// shared types and constants of the script text lexer
`timescale 1ns / 1ps

package slx_pkg;

	// default counter widths
	localparam int POS_BITS_DEF  = 24;
	localparam int LINE_BITS_DEF = 20;

	// fixed widths of the result fields
	localparam int OFF_W = 24;
	localparam int LN_W  = 20;

	// word slots per group (one character causes at most two), and queue depth in groups
	localparam int GRP_N   = 3;
	localparam int Q_DEPTH = 4;

	typedef enum logic [2:0] {
		M_SKIP    = 3'd0,
		M_COMMENT = 3'd1,
		M_SLASH   = 3'd2,
		M_WORD    = 3'd3,
		M_STRING  = 3'd4,
		M_QUOTE   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		K_OP   = 2'd0,
		K_WORD = 2'd1,
		K_STR  = 2'd2,
		K_ERR  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} src_word_t;

	typedef struct packed {
		logic [7:0]       token_char;
		logic             char_valid;
		logic [1:0]       token_kind;
		logic             token_first;
		logic             token_last;
		logic [OFF_W-1:0] token_offset;
		logic [LN_W-1:0]  token_line;
		logic             stream_end;
	} tok_word_t;

	// results of one character, oldest in item[0]
	typedef struct packed {
		logic [1:0]                cnt;
		tok_word_t [GRP_N-1:0]     item;
	} grp_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ sv/slx_front.sv @@
// front end: character scanner that turns each character into a group of words
`timescale 1ns / 1ps

module slx_front import slx_pkg::*; #(
	parameter int POS_BITS  = POS_BITS_DEF,
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  src_word_t src_word,
	input  q_stat_t   stat,
	output logic      push,
	output grp_t      grp
);

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;

	mode_t                mode_q;
	logic [7:0]           held_q;
	logic                 held_valid_q;
	logic [POS_BITS-1:0]  pos_q;
	logic [LINE_BITS-1:0] line_q;
	logic [POS_BITS-1:0]  tstart_q;
	logic                 first_q;

	mode_t                mode_d;
	logic [7:0]           held_d;
	logic                 held_valid_d;
	logic [LINE_BITS-1:0] line_d;
	logic [POS_BITS-1:0]  tstart_d;
	logic                 first_d;
	logic [POS_BITS-1:0]  pos_inc;
	logic                 accept;

	function automatic logic is_space(input logic [7:0] c);
		logic r;
		case (c) inside
			CH_SPACE, CH_TAB, CH_CR, CH_LF: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_oper(input logic [7:0] c);
		logic r;
		case (c) inside
			CH_COMMA, CH_EQ, CH_LPAR, CH_RPAR, CH_SEMI, CH_LBRC, CH_RBRC,
			CH_LT, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_GT: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic tok_word_t mk(input logic [7:0] ch, input logic vld, input kind_t kind,
			input logic first, input logic last, input logic [POS_BITS-1:0] off,
			input logic [LINE_BITS-1:0] line);
		tok_word_t w;
		w.token_char   = ch;
		w.char_valid   = vld;
		w.token_kind   = kind;
		w.token_first  = first;
		w.token_last   = last;
		w.token_offset = OFF_W'(off);
		w.token_line   = LN_W'(line);
		w.stream_end   = 1'b0;
		return w;
	endfunction

	assign src_ready = !stat.full;
	assign accept    = src_valid && src_ready;
	assign pos_inc   = (&pos_q) ? pos_q : pos_q + 1'b1;

	// scan one character: next state and the words it causes
	always_comb begin
		logic [7:0] c;
		logic       do_skip;
		logic [1:0] n;
		c            = src_word.in_char;
		do_skip      = 1'b0;
		n            = 2'd0;
		grp          = '0;
		mode_d       = mode_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		line_d       = line_q;
		tstart_d     = tstart_q;
		first_d      = first_q;

		unique case (mode_q)
			M_COMMENT: begin
				if (c == CH_LF) begin
					line_d = (&line_d) ? line_d : line_d + 1'b1;
					mode_d = M_SKIP;
				end
			end
			M_SLASH: begin
				if (c == CH_SLASH) begin
					mode_d       = M_COMMENT;
					held_valid_d = 1'b0;
				end else begin
					grp.item[n]  = mk(CH_SLASH, 1'b1, K_OP, 1'b1, 1'b1, tstart_d, line_d);
					n            = n + 2'd1;
					held_valid_d = 1'b0;
					do_skip      = 1'b1;
				end
			end
			M_WORD: begin
				if (is_space(c) || is_oper(c) || c == CH_HASH) begin
					grp.item[n]  = mk(held_d, 1'b1, K_WORD, first_d, 1'b1, tstart_d, line_d);
					n            = n + 2'd1;
					held_valid_d = 1'b0;
					first_d      = 1'b1;
					do_skip      = 1'b1;
				end else begin
					grp.item[n] = mk(held_d, 1'b1, K_WORD, first_d, 1'b0, tstart_d, line_d);
					n           = n + 2'd1;
					first_d     = 1'b0;
					held_d      = c;
				end
			end
			M_STRING: begin
				if (c == CH_QUOTE) begin
					mode_d = M_QUOTE;
				end else begin
					if (held_valid_d) begin
						grp.item[n] = mk(held_d, 1'b1, K_STR, first_d, 1'b0, '0, line_d);
						n           = n + 2'd1;
						first_d     = 1'b0;
					end
					held_d       = c;
					held_valid_d = 1'b1;
				end
			end
			M_QUOTE: begin
				if (c == CH_QUOTE) begin
					// doubled quote stands for one quote character
					if (held_valid_d) begin
						grp.item[n] = mk(held_d, 1'b1, K_STR, first_d, 1'b0, '0, line_d);
						n           = n + 2'd1;
						first_d     = 1'b0;
					end
					held_d       = CH_QUOTE;
					held_valid_d = 1'b1;
					mode_d       = M_STRING;
				end else begin
					if (held_valid_d)
						grp.item[n] = mk(held_d, 1'b1, K_STR, first_d, 1'b1, pos_q, line_d);
					else
						grp.item[n] = mk(8'h00, 1'b0, K_STR, 1'b1, 1'b1, pos_q, line_d);
					n            = n + 2'd1;
					held_valid_d = 1'b0;
					first_d      = 1'b1;
					do_skip      = 1'b1;
				end
			end
			default: begin
				do_skip = 1'b1;
			end
		endcase

		// character seen with no token open
		if (do_skip) begin
			mode_d = M_SKIP;
			if (c == CH_HASH) begin
				mode_d = M_COMMENT;
			end else if (c == CH_SLASH) begin
				mode_d       = M_SLASH;
				held_d       = c;
				held_valid_d = 1'b1;
				tstart_d     = pos_q;
			end else if (is_space(c)) begin
				if (c == CH_LF)
					line_d = (&line_d) ? line_d : line_d + 1'b1;
			end else if (is_oper(c)) begin
				grp.item[n] = mk(c, 1'b1, K_OP, 1'b1, 1'b1, pos_q, line_d);
				n           = n + 2'd1;
			end else if (c == CH_QUOTE) begin
				mode_d       = M_STRING;
				held_valid_d = 1'b0;
				first_d      = 1'b1;
				tstart_d     = pos_q;
			end else begin
				mode_d       = M_WORD;
				held_d       = c;
				held_valid_d = 1'b1;
				first_d      = 1'b1;
				tstart_d     = pos_q;
			end
		end

		// buffer end flushes the open token
		if (src_word.in_last) begin
			case (mode_d)
				M_SLASH: begin
					grp.item[n] = mk(CH_SLASH, 1'b1, K_OP, 1'b1, 1'b1, tstart_d, line_d);
					n           = n + 2'd1;
				end
				M_WORD: begin
					grp.item[n] = mk(held_d, 1'b1, K_WORD, first_d, 1'b1, tstart_d, line_d);
					n           = n + 2'd1;
				end
				M_STRING: begin
					grp.item[n] = mk(8'h00, 1'b0, K_ERR, 1'b1, 1'b1, tstart_d, line_d);
					n           = n + 2'd1;
				end
				M_QUOTE: begin
					if (held_valid_d)
						grp.item[n] = mk(held_d, 1'b1, K_STR, first_d, 1'b1, pos_inc, line_d);
					else
						grp.item[n] = mk(8'h00, 1'b0, K_STR, 1'b1, 1'b1, pos_inc, line_d);
					n = n + 2'd1;
				end
				default: begin
				end
			endcase
			// status-only word when nothing else goes out
			if (n == 2'd0) begin
				grp.item[n] = mk(8'h00, 1'b0, K_OP, 1'b0, 1'b0, pos_inc, line_d);
				n           = n + 2'd1;
			end
			grp.item[n - 2'd1].stream_end = 1'b1;
		end
		grp.cnt = n;
	end

	assign push = accept && (grp.cnt != 2'd0);

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_SKIP;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			pos_q        <= '0;
			line_q       <= '0;
			tstart_q     <= '0;
			first_q      <= 1'b1;
		end else if (accept) begin
			if (src_word.in_last) begin
				mode_q       <= M_SKIP;
				held_q       <= '0;
				held_valid_q <= 1'b0;
				pos_q        <= '0;
				line_q       <= '0;
				tstart_q     <= '0;
				first_q      <= 1'b1;
			end else begin
				mode_q       <= mode_d;
				held_q       <= held_d;
				held_valid_q <= held_valid_d;
				pos_q        <= pos_inc;
				line_q       <= line_d;
				tstart_q     <= tstart_d;
				first_q      <= first_d;
			end
		end
	end

	// buffer end always leaves a clean scanner
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready && src_word.in_last |=>
			mode_q == M_SKIP && pos_q == '0 && line_q == '0 && !held_valid_q)
		else $error("scanner state not cleared after buffer end");

	// buffer end always produces at least one word
	a_end_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready && src_word.in_last |-> push)
		else $error("buffer end without a word");

	// a word group never goes to a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("push into full queue");

endmodule

@@ sv/slx_queue.sv @@
// queue of word groups between scanner and output stage
`timescale 1ns / 1ps

module slx_queue import slx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  grp_t    grp_in,
	input  logic    pop,
	output grp_t    head,
	output q_stat_t stat
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	grp_t             slot_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == CNT_W'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= grp_in;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");

	a_fill_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("fill count lost a push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> wr_ptr_q == rd_ptr_q)
		else $error("pointers apart on empty queue");

endmodule

@@ sv/slx_back.sv @@
// back end: sends the words of each group one per cycle, while tok_ready allows, through an output register
`timescale 1ns / 1ps

module slx_back import slx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  grp_t      head,
	input  q_stat_t   stat,
	output logic      pop,
	output logic      tok_valid,
	input  logic      tok_ready,
	output tok_word_t tok_word
);

	logic       out_valid_q;
	tok_word_t  out_q;
	logic [1:0] idx_q;
	logic       load;
	logic       take;
	logic       grp_done;

	assign load     = !out_valid_q || tok_ready;
	assign take     = load && !stat.empty;
	assign grp_done = (idx_q == head.cnt - 2'd1);
	assign pop      = take && grp_done;

	assign tok_valid = out_valid_q;
	assign tok_word  = out_q;

	// output register
	always_ff @(posedge clk) begin
		if (take)
			out_q <= head.item[idx_q];
	end

	// output valid and position within the head group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load)
				out_valid_q <= !stat.empty;
			if (take)
				idx_q <= grp_done ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

@@ sv/script_text_lexer.sv @@
// top level of the script text lexer
//
//  channel    | direction | handshake              | word
//  src        | in        | src_valid / src_ready  | src_word_t: in_char, in_last
//  tok        | out       | tok_valid / tok_ready  | tok_word_t: one token character
//
// one character is taken per cycle while the group queue has room; the scanner
// computes its next state in combinational compare logic
// each character yields zero to two words, sent one per cycle from the output
// register while tok_ready allows
// a stalled output fills the four-group queue, then src_ready drops
// words pass the queue, then the output register; reset empties queue and scanner
`timescale 1ns / 1ps

module script_text_lexer import slx_pkg::*; #(
	parameter int POS_BITS  = POS_BITS_DEF,
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  src_word_t src_word,
	output logic      tok_valid,
	input  logic      tok_ready,
	output tok_word_t tok_word
);

	q_stat_t stat;
	grp_t    grp;
	grp_t    head;
	logic    push;
	logic    pop;

	// scanner
	slx_front #(
		.POS_BITS  (POS_BITS),
		.LINE_BITS (LINE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_word  (src_word),
		.stat      (stat),
		.push      (push),
		.grp       (grp)
	);

	// group queue
	slx_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.grp_in (grp),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	// word serializer
	slx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_word  (tok_word)
	);

endmodule

@@ dv/slx_token_monitor.sv @@
// token stream predictor and checker for the script text lexer
`timescale 1ns / 1ps

module slx_token_monitor import slx_pkg::*; #(
	parameter int POS_BITS  = POS_BITS_DEF,
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	input  logic      src_ready,
	input  src_word_t src_word,
	input  logic      tok_valid,
	input  logic      tok_ready,
	input  tok_word_t tok_word,
	output int        mismatches,
	output int        tokens_owed
);

	localparam logic [POS_BITS-1:0]  POS_TOP    = '1;
	localparam logic [LINE_BITS-1:0] LINE_TOP   = '1;
	localparam int                   REPORT_MAX = 10;
	localparam int                   STEP_MAX   = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// scanner state mirrored from the block
	mode_t                scan_mode;
	logic [7:0]           held_ch;
	logic                 held_v;
	logic [POS_BITS-1:0]  char_pos;
	logic [LINE_BITS-1:0] line_no;
	logic [POS_BITS-1:0]  tok_start;
	logic                 first_pend;

	// predicted token words, oldest first
	tok_word_t expected_tokens[$];
	tok_word_t step_tokens[STEP_MAX];
	int        step_n;
	int        reported;

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		case (c)
			",", "=", "(", ")", ";", "{", "}", "<", "+", "-", "*", "/", ">": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic reset_scan();
		scan_mode  = M_SKIP;
		held_ch    = CH_NUL;
		held_v     = 1'b0;
		char_pos   = '0;
		line_no    = '0;
		tok_start  = '0;
		first_pend = 1'b1;
	endtask

	task automatic bump_line();
		if (line_no != LINE_TOP) begin
			line_no = line_no + 1'b1;
		end
	endtask

	// append one predicted word at the tail
	task automatic queue_token(input tok_word_t w);
		expected_tokens = {expected_tokens, w};
	endtask

	// collect one predicted word for the current character
	task automatic add_token(input logic [7:0] ch, input logic cv, input kind_t k,
		input logic f, input logic l, input logic [POS_BITS-1:0] off);
		tok_word_t w;
		if (step_n < STEP_MAX) begin
			w.token_char   = ch;
			w.char_valid   = cv;
			w.token_kind   = k;
			w.token_first  = f;
			w.token_last   = l;
			w.token_offset = OFF_W'(off);
			w.token_line   = LN_W'(line_no);
			w.stream_end   = 1'b0;
			step_tokens[step_n] = w;
			step_n++;
		end
	endtask

	// scan a character with no token open
	task automatic open_token(input logic [7:0] c, input logic [POS_BITS-1:0] here);
		scan_mode = M_SKIP;
		if (c == CH_HASH) begin
			scan_mode = M_COMMENT;
		end else if (c == CH_SLASH) begin
			scan_mode = M_SLASH;
			held_ch   = c;
			held_v    = 1'b1;
			tok_start = here;
		end else if (is_blank(c)) begin
			if (c == CH_LF) begin
				bump_line();
			end
		end else if (is_op(c)) begin
			add_token(c, 1'b1, K_OP, 1'b1, 1'b1, here);
		end else if (c == CH_QUOTE) begin
			scan_mode  = M_STRING;
			held_v     = 1'b0;
			first_pend = 1'b1;
			tok_start  = here;
		end else begin
			scan_mode  = M_WORD;
			held_ch    = c;
			held_v     = 1'b1;
			first_pend = 1'b1;
			tok_start  = here;
		end
	endtask

	// closing quote confirmed: flush the held character or an empty string
	task automatic close_quoted(input logic [POS_BITS-1:0] off);
		if (held_v) begin
			add_token(held_ch, 1'b1, K_STR, first_pend, 1'b1, off);
		end else begin
			add_token(CH_NUL, 1'b0, K_STR, 1'b1, 1'b1, off);
		end
		held_v     = 1'b0;
		first_pend = 1'b1;
	endtask

	// string character: send the held one, keep the new one back
	task automatic push_quoted(input logic [7:0] c);
		if (held_v) begin
			add_token(held_ch, 1'b1, K_STR, first_pend, 1'b0, '0);
			first_pend = 1'b0;
		end
		held_ch = c;
		held_v  = 1'b1;
	endtask

	// predict the words caused by one accepted character
	task automatic scan_char(input logic [7:0] c, input logic lst);
		logic [POS_BITS-1:0] here;
		logic [POS_BITS-1:0] len;
		here   = char_pos;
		step_n = 0;
		case (scan_mode)
			M_COMMENT: begin
				if (c == CH_LF) begin
					bump_line();
					scan_mode = M_SKIP;
				end
			end
			M_SLASH: begin
				if (c == CH_SLASH) begin
					scan_mode = M_COMMENT;
					held_v    = 1'b0;
				end else begin
					add_token(CH_SLASH, 1'b1, K_OP, 1'b1, 1'b1, tok_start);
					held_v = 1'b0;
					open_token(c, here);
				end
			end
			M_WORD: begin
				if (is_blank(c) || is_op(c) || c == CH_HASH) begin
					add_token(held_ch, 1'b1, K_WORD, first_pend, 1'b1, tok_start);
					held_v     = 1'b0;
					first_pend = 1'b1;
					open_token(c, here);
				end else begin
					add_token(held_ch, 1'b1, K_WORD, first_pend, 1'b0, tok_start);
					first_pend = 1'b0;
					held_ch    = c;
				end
			end
			M_STRING: begin
				if (c == CH_QUOTE) begin
					scan_mode = M_QUOTE;
				end else begin
					push_quoted(c);
				end
			end
			M_QUOTE: begin
				if (c == CH_QUOTE) begin
					push_quoted(CH_QUOTE);
					scan_mode = M_STRING;
				end else begin
					close_quoted(here);
					open_token(c, here);
				end
			end
			default: begin
				open_token(c, here);
			end
		endcase

		len = (here == POS_TOP) ? here : here + 1'b1;
		if (lst) begin
			// buffer end: flush what is open, then start over
			case (scan_mode)
				M_SLASH:  add_token(CH_SLASH, 1'b1, K_OP, 1'b1, 1'b1, tok_start);
				M_WORD:   add_token(held_ch, 1'b1, K_WORD, first_pend, 1'b1, tok_start);
				M_STRING: add_token(CH_NUL, 1'b0, K_ERR, 1'b1, 1'b1, tok_start);
				M_QUOTE:  close_quoted(len);
				default: ;
			endcase
			if (step_n == 0) begin
				add_token(CH_NUL, 1'b0, K_OP, 1'b0, 1'b0, len);
			end
			step_tokens[step_n - 1].stream_end = 1'b1;
			reset_scan();
		end else begin
			char_pos = len;
		end

		for (int i = 0; i < step_n; i++) begin
			queue_token(step_tokens[i]);
		end
	endtask

	// compare one output word with the oldest prediction
	task automatic check_token(input tok_word_t got);
		tok_word_t want;
		logic      bad;
		if (expected_tokens.size() == 0) begin
			mismatches++;
			if (reported < REPORT_MAX) begin
				$display("unexpected token word: char %02h valid %0d kind %0d off %0d line %0d",
					got.token_char, got.char_valid, got.token_kind, got.token_offset,
					got.token_line);
			end
			reported++;
		end else begin
			want = expected_tokens[0];
			expected_tokens.delete(0);
			bad  = got.token_char !== want.token_char || got.char_valid !== want.char_valid ||
				got.token_kind !== want.token_kind || got.token_first !== want.token_first ||
				got.token_last !== want.token_last || got.token_offset !== want.token_offset ||
				got.token_line !== want.token_line || got.stream_end !== want.stream_end;
			if (bad) begin
				mismatches++;
				if (reported < REPORT_MAX) begin
					$display("exp: ch %02h v %0d k %0d f %0d l %0d off %0d ln %0d end %0d",
						want.token_char, want.char_valid, want.token_kind, want.token_first,
						want.token_last, want.token_offset, want.token_line, want.stream_end);
					$display("got: ch %02h v %0d k %0d f %0d l %0d off %0d ln %0d end %0d",
						got.token_char, got.char_valid, got.token_kind, got.token_first,
						got.token_last, got.token_offset, got.token_line, got.stream_end);
				end
				reported++;
			end
		end
	endtask

	// watch both channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_scan();
			expected_tokens.delete();
			mismatches  = 0;
			tokens_owed = 0;
			reported    = 0;
		end else begin
			if (src_valid && src_ready) begin
				scan_char(src_word.in_char, src_word.in_last);
			end
			if (tok_valid && tok_ready) begin
				check_token(tok_word);
			end
			tokens_owed = expected_tokens.size();
		end
	end

endmodule

@@ dv/tb_top.sv @@
// testbench top: clock, reset, character stimulus and verdict for the script text lexer
`timescale 1ns / 1ps

module tb_top import slx_pkg::*; ();

	localparam int ITEM_TARGET  = 370;
	localparam int QUIET_ITEMS  = 50;
	localparam int HOLD_AT      = 80;
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 20;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LOW_A = 8'h61;

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_ready;
	src_word_t src_word;
	logic      tok_valid;
	logic      tok_ready;
	tok_word_t tok_word;
	logic      src_fire;
	logic      quiet;

	int mismatches;
	int tokens_owed;
	int sent_count;
	int cycle_count;

	logic [7:0] script_q[$];
	logic [7:0] op_chars[13] = '{",", "=", "(", ")", ";", "{", "}", "<", "+", "-", "*", "/", ">"};
	logic [7:0] blank_chars[4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

	script_text_lexer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_word  (src_word),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_word  (tok_word)
	);

	slx_token_monitor monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_ready   (src_ready),
		.src_word    (src_word),
		.tok_valid   (tok_valid),
		.tok_ready   (tok_ready),
		.tok_word    (tok_word),
		.mismatches  (mismatches),
		.tokens_owed (tokens_owed)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// input handshake seen at the rising edge, read back at the falling one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fire <= 1'b0;
		end else begin
			src_fire <= src_valid && src_ready;
		end
	end

	// offer one character and wait until it is taken
	task automatic send_char(input logic [7:0] c, input logic lst);
		int gap;
		src_word  <= '{in_char: c, in_last: lst};
		src_valid <= 1'b1;
		@(negedge clk);
		while (!src_fire) begin
			@(negedge clk);
		end
		sent_count++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			src_valid <= 1'b0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_script();
		for (int i = 0; i < script_q.size(); i++) begin
			send_char(script_q[i], i == script_q.size() - 1);
		end
	endtask

	// add one character at the end of the buffer under construction
	task automatic append_char(input logic [7:0] c);
		script_q = {script_q, c};
	endtask

	// random buffer built from token-like pieces plus noise
	task automatic build_random_script();
		int         n_tok;
		int         len;
		logic [7:0] ch;
		script_q.delete();
		n_tok = $urandom_range(1, 10);
		repeat (n_tok) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					// word, sometimes with a quote or a raw byte inside
					append_char(CH_LOW_A + 8'($urandom_range(0, 25)));
					len = $urandom_range(0, 5);
					repeat (len) begin
						case ($urandom_range(0, 7))
							0:       ch = CH_QUOTE;
							1:       ch = 8'($urandom_range(0, 255));
							default: ch = CH_LOW_A + 8'($urandom_range(0, 25));
						endcase
						append_char(ch);
					end
				end
				2, 3: begin
					append_char(op_chars[$urandom_range(0, 12)]);
				end
				4: begin
					len = $urandom_range(1, 3);
					repeat (len) append_char(blank_chars[$urandom_range(0, 3)]);
				end
				5, 6: begin
					// quoted string, any bytes, quotes doubled
					append_char(CH_QUOTE);
					len = $urandom_range(0, 5);
					repeat (len) begin
						ch = 8'($urandom_range(0, 255));
						append_char(ch);
						if (ch == CH_QUOTE) begin
							append_char(CH_QUOTE);
						end
					end
					append_char(CH_QUOTE);
				end
				7: begin
					// line comment opened by hash or double slash
					if ($urandom_range(0, 1) == 0) begin
						append_char(CH_HASH);
					end else begin
						append_char(CH_SLASH);
						append_char(CH_SLASH);
					end
					len = $urandom_range(0, 4);
					repeat (len) begin
						ch = 8'($urandom_range(0, 255));
						append_char((ch == CH_LF) ? CH_SPACE : ch);
					end
					if ($urandom_range(0, 3) != 0) begin
						append_char(CH_LF);
					end
				end
				default: begin
					append_char(8'($urandom_range(0, 255)));
				end
			endcase
		end
		// now and then a string left open at buffer end
		if ($urandom_range(0, 7) == 0) begin
			append_char(CH_QUOTE);
			len = $urandom_range(0, 3);
			repeat (len) append_char(CH_LOW_A + 8'($urandom_range(0, 25)));
		end
	endtask

	// output side: random stalls, one long hold-off, none at the end
	initial begin
		int hold;
		bit long_done;
		tok_ready = 1'b0;
		hold      = 0;
		long_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				tok_ready <= 1'b0;
				hold--;
			end else if (!long_done && sent_count >= HOLD_AT) begin
				tok_ready <= 1'b0;
				hold      = LONG_HOLD - 1;
				long_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				tok_ready <= 1'b0;
				hold      = $urandom_range(1, 18) - 1;
			end else begin
				tok_ready <= 1'b1;
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// stimulus and verdict
	initial begin
		int waited;
		arst_n        = 1'b0;
		src_valid     = 1'b0;
		src_word      = '0;
		quiet         = 1'b0;
		sent_count    = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// nul word with a quote inside, ended by a hash comment, then an operator
		script_q = '{CH_NUL, CH_QUOTE, CH_HASH, "z", CH_LF, ","};
		send_script();
		// double slash comment, high byte word, slash as final character
		script_q = '{CH_SLASH, CH_SLASH, "c", CH_LF, 8'hFF, CH_SLASH};
		send_script();
		// lone slash, string with a doubled quote closed by the final quote
		script_q = '{CH_SLASH, CH_QUOTE, "a", CH_QUOTE, CH_QUOTE, CH_QUOTE};
		send_script();
		// empty string
		script_q = '{CH_QUOTE, CH_QUOTE, CH_SPACE};
		send_script();
		// string left open
		script_q = '{CH_QUOTE, "q"};
		send_script();
		// blanks only, status word at the end
		script_q = '{CH_SPACE, CH_TAB, CH_CR};
		send_script();

		while (sent_count < ITEM_TARGET) begin
			build_random_script();
			send_script();
			quiet = (sent_count >= ITEM_TARGET - QUIET_ITEMS);
		end
		src_valid <= 1'b0;

		// drain and settle
		waited = 0;
		while (tokens_owed != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0 && tokens_owed == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
